### rtl/core/two_register_stack_cpu_execute_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-register stack CPU execute block
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TWO_REGISTER_STACK_CPU_EXECUTE_DEFINES_SVH
`define TWO_REGISTER_STACK_CPU_EXECUTE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define TRSCE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define TRSCE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/trsce_pkg.sv
// ----------------------------------------------------------------------------
// trsce_pkg
// Opcodes, constants and controller/datapath interface types for the
// two-register stack CPU execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package trsce_pkg;

    // Memory depth default; the depth must be a power of two (address wraps)
    localparam int unsigned MEM_WORDS_DEF = 65536;

    // Field widths
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned MEM_ADDR_W = 16;
    localparam int unsigned S_DATA_W   = 80;
    localparam int unsigned M_DATA_W   = 248;

    // Register values after reset
    localparam logic [WORD_W-1:0] RESET_A  = 32'd8483536;
    localparam logic [WORD_W-1:0] RESET_B  = 32'd134518156;
    localparam logic [WORD_W-1:0] RESET_SP = 32'd134518166;

    // Item kinds carried in tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EXEC = 1'b1;

    // Instruction opcodes
    typedef enum logic [7:0] {
        OP_LDC  = 8'd0,
        OP_ADC  = 8'd1,
        OP_LDL  = 8'd2,
        OP_STL  = 8'd3,
        OP_LDNL = 8'd4,
        OP_STNL = 8'd5,
        OP_ADD  = 8'd6,
        OP_SUB  = 8'd7,
        OP_SHL  = 8'd8,
        OP_SHR  = 8'd9,
        OP_ADJ  = 8'd10,
        OP_A2SP = 8'd11,
        OP_SP2A = 8'd12,
        OP_CALL = 8'd13,
        OP_RET  = 8'd14,
        OP_BRZ  = 8'd15,
        OP_BRLZ = 8'd16,
        OP_BR   = 8'd17,
        OP_HALT = 8'd18
    } opcode_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_wr;   // write zero at the clear counter and advance it
        logic accept;     // capture input transaction, issue memory read
        logic commit;     // update machine state, memory and output register
    } trsce_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last; // clear counter at the last memory word
        logic out_free;   // output register can take a result this cycle
    } trsce_status_t;

endpackage

`default_nettype wire

### rtl/core/two_register_stack_cpu_execute.sv
// After reset the block sweeps its word memory to zero, one word per cycle,
// and holds s_tready low until the sweep ends. From then on it takes one
// transaction at a time: when a transaction is accepted the memory address
// is formed from SP or A plus the operand (or from the load address) and
// the single memory read port is read; then, in the execute state, the
// instruction executes and commits registers, memory and the result
// register. A result waits in the output register while the next
// transaction is accepted; commit stalls only when that register is still
// full.
// ----------------------------------------------------------------------------
// two_register_stack_cpu_execute
// Executes one instruction, or loads one memory word, per input transaction
// of a two-register accumulator machine and reports the state afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module two_register_stack_cpu_execute #(
    parameter int unsigned MEM_WORDS = trsce_pkg::MEM_WORDS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // instruction_word[31:0], load_addr[47:32], load_data[79:48]
    input  wire logic [trsce_pkg::S_DATA_W-1:0]  s_tdata,
    // func
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // next_pc[31:0], reg_a[63:32], reg_b[95:64], stack_ptr[127:96],
    // halted[128], mem_read[129], mem_write[130], mem_addr[146:131],
    // mem_before[178:147], mem_after[210:179], executed_count[242:211],
    // zero fill[247:243]
    output logic      [trsce_pkg::M_DATA_W-1:0]  m_tdata
);
    import trsce_pkg::*;

    trsce_cmd_t    cmd;
    trsce_status_t status;

    trsce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    trsce_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/core/trsce_ctrl.sv
// ----------------------------------------------------------------------------
// trsce_ctrl
// Sequencer: memory clear after reset, accept, execute and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module trsce_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire trsce_pkg::trsce_status_t status,
    output trsce_pkg::trsce_cmd_t        cmd
);
    import trsce_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.clear_wr = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait for room in the output register
                cmd.commit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/trsce_datapath.sv
// ----------------------------------------------------------------------------
// trsce_datapath
// Machine registers, word memory, instruction execute logic and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trsce_datapath #(
    parameter int unsigned MEM_WORDS = trsce_pkg::MEM_WORDS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire trsce_pkg::trsce_cmd_t             cmd,
    output trsce_pkg::trsce_status_t               status,
    input  wire logic [trsce_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [trsce_pkg::M_DATA_W-1:0]    m_tdata
);
    import trsce_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MEM_WORDS);

    // Word memory
    logic [WORD_W-1:0] mem [MEM_WORDS];

    // Machine state
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] sp_reg, sp_next;
    logic [WORD_W-1:0] pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic [WORD_W-1:0] cnt_reg, cnt_next;

    // Captured transaction
    logic              func_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] ldata_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0] rdata_reg;

    // Clear sweep
    logic [ADDR_W-1:0] clr_cnt_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_DATA_W-1:0] m_tdata_next;

    // Address generation at accept
    logic [7:0]        in_op;
    logic [WORD_W-1:0] in_imm;
    logic [WORD_W-1:0] in_base;
    logic [WORD_W-1:0] in_addr_full;
    logic [ADDR_W-1:0] in_addr;

    always_comb begin
        in_op  = s_tdata[7:0];
        in_imm = {{8{s_tdata[31]}}, s_tdata[31:8]};
        if (in_op == OP_LDL || in_op == OP_STL) begin
            in_base = sp_reg;
        end else begin
            in_base = a_reg;
        end
        if (s_tuser == FUNC_LOAD) begin
            in_addr_full = {16'd0, s_tdata[47:32]};
        end else begin
            in_addr_full = in_base + in_imm;
        end
        in_addr = in_addr_full[ADDR_W-1:0];
    end

    // Capture transaction
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg  <= s_tuser;
            word_reg  <= s_tdata[31:0];
            ldata_reg <= s_tdata[79:48];
            addr_reg  <= in_addr;
        end
    end

    // Execute
    logic [7:0]        op;
    logic [WORD_W-1:0] imm;
    logic [WORD_W-1:0] pc_inc;
    logic [WORD_W-1:0] pc_jump;
    logic              acc;
    logic              rd;
    logic              wr;
    logic [WORD_W-1:0] prev_word;
    logic [WORD_W-1:0] after;
    logic [WORD_W-1:0] mem_wdata;
    logic [MEM_ADDR_W-1:0] out_addr;

    always_comb begin
        op      = word_reg[7:0];
        imm     = {{8{word_reg[31]}}, word_reg[31:8]};
        pc_inc  = pc_reg + 32'd1;
        pc_jump = pc_reg + imm + 32'd1;

        a_next    = a_reg;
        b_next    = b_reg;
        sp_next   = sp_reg;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        cnt_next  = cnt_reg;
        acc       = 1'b0;
        rd        = 1'b0;
        wr        = 1'b0;
        prev_word = '0;
        after     = '0;
        mem_wdata = ldata_reg;

        if (func_reg == FUNC_LOAD) begin
            acc       = 1'b1;
            wr        = 1'b1;
            prev_word = rdata_reg;
            after     = ldata_reg;
        end else if (!halt_reg) begin
            pc_next  = pc_inc;
            cnt_next = cnt_reg + 32'd1;
            unique case (op)
                OP_LDC: begin
                    b_next = a_reg;
                    a_next = imm;
                end
                OP_ADC: begin
                    a_next = a_reg + imm;
                end
                OP_LDL: begin
                    b_next    = a_reg;
                    a_next    = rdata_reg;
                    acc       = 1'b1;
                    rd        = 1'b1;
                    prev_word = rdata_reg;
                    after     = rdata_reg;
                end
                OP_STL: begin
                    mem_wdata = a_reg;
                    a_next    = b_reg;
                    acc       = 1'b1;
                    wr        = 1'b1;
                    prev_word = rdata_reg;
                    after     = a_reg;
                end
                OP_LDNL: begin
                    a_next    = rdata_reg;
                    acc       = 1'b1;
                    rd        = 1'b1;
                    prev_word = rdata_reg;
                    after     = rdata_reg;
                end
                OP_STNL: begin
                    mem_wdata = b_reg;
                    acc       = 1'b1;
                    wr        = 1'b1;
                    prev_word = rdata_reg;
                    after     = b_reg;
                end
                OP_ADD: begin
                    a_next = b_reg + a_reg;
                end
                OP_SUB: begin
                    a_next = b_reg - a_reg;
                end
                OP_SHL: begin
                    // an amount of 32 or more clears the word
                    if (|a_reg[31:5]) begin
                        a_next = '0;
                    end else begin
                        a_next = b_reg << a_reg[4:0];
                    end
                end
                OP_SHR: begin
                    // an amount of 32 or more leaves only sign fill
                    if (|a_reg[31:5]) begin
                        a_next = {WORD_W{b_reg[31]}};
                    end else begin
                        a_next = WORD_W'($signed(b_reg) >>> a_reg[4:0]);
                    end
                end
                OP_ADJ: begin
                    sp_next = sp_reg + imm;
                end
                OP_A2SP: begin
                    sp_next = a_reg;
                    a_next  = b_reg;
                end
                OP_SP2A: begin
                    b_next = a_reg;
                    a_next = sp_reg;
                end
                OP_CALL: begin
                    b_next  = a_reg;
                    a_next  = pc_inc;
                    pc_next = pc_jump;
                end
                OP_RET: begin
                    pc_next = a_reg;
                    a_next  = b_reg;
                end
                OP_BRZ: begin
                    if (a_reg == '0) begin
                        pc_next = pc_jump;
                    end
                end
                OP_BRLZ: begin
                    if (a_reg[31]) begin
                        pc_next = pc_jump;
                    end
                end
                OP_BR: begin
                    pc_next = pc_jump;
                end
                OP_HALT: begin
                    halt_next = 1'b1;
                end
                default: begin
                    // unknown opcode: only PC and count advance
                end
            endcase
        end

        if (acc) begin
            out_addr = MEM_ADDR_W'(WORD_W'(addr_reg));
        end else begin
            out_addr = '0;
        end

        m_tdata_next = {5'd0, cnt_next, after, prev_word, out_addr, wr, rd, halt_next,
                        sp_next, b_next, a_next, pc_next};
    end

    // Update machine state on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg    <= RESET_A;
            b_reg    <= RESET_B;
            sp_reg   <= RESET_SP;
            pc_reg   <= '0;
            halt_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.commit) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            sp_reg   <= sp_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    // Memory: one write port (clear or commit), one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.commit && wr) begin
            mem[addr_reg] <= mem_wdata;
        end
        if (cmd.accept) begin
            rdata_reg <= mem[in_addr];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = m_tdata_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.clear_last = (clr_cnt_reg == ADDR_W'(MEM_WORDS - 1));

endmodule

`default_nettype wire

### rtl/core/trsce_checker.sv
// ----------------------------------------------------------------------------
// trsce_checker
// Port-level checks for the two-register stack CPU execute block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_register_stack_cpu_execute_defines.svh"

module trsce_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [trsce_pkg::M_DATA_W-1:0] m_tdata
);
    import trsce_pkg::*;

    // Hold a stalled result
    `TRSCE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // One transaction in flight: no accept in the cycle after an accept
    `TRSCE_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input accepted while busy")

    // Block input when reset is released, as the clear sweep begins
    `TRSCE_ASSERT(a_clear_blocks, aclk, aresetn, $rose(aresetn) |-> !s_tready, "input ready during clear")

    // A transaction never reads and writes memory at once
    `TRSCE_ASSERT(a_rd_wr_excl, aclk, aresetn, m_tvalid |-> !(m_tdata[129] && m_tdata[130]), "read and write flagged together")

    // Drop any result during reset
    `TRSCE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind two_register_stack_cpu_execute trsce_checker u_trsce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/two_register_stack_cpu_execute_test.sv
// ----------------------------------------------------------------------------
// two_register_stack_cpu_execute_test
// Drives load and execute transactions into the accumulator machine, tracks
// registers, PC, halt flag, instruction count and word memory in a local
// machine model, and checks every result transaction field by field. Both
// stream sides idle at random; pauses drain all results, also before the halt.
// ----------------------------------------------------------------------------
module two_register_stack_cpu_execute_test;
    import trsce_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1500000;
    localparam int unsigned RANDOM_ITEMS = 1950;

    // One input transaction as the driver sees it
    typedef struct {
        logic        func;
        logic [31:0] word;
        logic [15:0] load_addr;
        logic [31:0] load_data;
        logic        drain;
    } cpu_item_t;

    // Result word in the m_tdata layout (first member holds the top bits)
    typedef struct packed {
        logic [4:0]  fill;
        logic [31:0] executed_count;
        logic [31:0] mem_after;
        logic [31:0] mem_before;
        logic [15:0] mem_addr;
        logic        mem_write;
        logic        mem_read;
        logic        halted;
        logic [31:0] stack_ptr;
        logic [31:0] reg_b;
        logic [31:0] reg_a;
        logic [31:0] next_pc;
    } cpu_report_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    // Machine model state
    logic [31:0] cpu_a;
    logic [31:0] cpu_b;
    logic [31:0] cpu_sp;
    logic [31:0] cpu_pc;
    logic        cpu_halt;
    logic [31:0] cpu_count;
    logic [31:0] cpu_mem [MEM_WORDS_DEF];

    cpu_item_t   pending_items[$];
    cpu_report_t expected_reports[$];
    int unsigned items_total;
    int unsigned items_accepted;
    int unsigned err_count;
    int unsigned cycle_count;
    bit          in_accepted;
    int unsigned send_gap;
    int unsigned stall_left;

    two_register_stack_cpu_execute dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Quiet stretches with no idling on either side
    function automatic bit quiet_phase();
        return (cycle_count[10:9] == 2'b00);
    endfunction

    task automatic push_load(input logic [15:0] addr, input logic [31:0] data);
        cpu_item_t it;
        it.func      = FUNC_LOAD;
        it.word      = $urandom;
        it.load_addr = addr;
        it.load_data = data;
        it.drain     = 1'b0;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_raw_exec(input logic [31:0] word);
        cpu_item_t it;
        it.func      = FUNC_EXEC;
        it.word      = word;
        it.load_addr = 16'($urandom);
        it.load_data = $urandom;
        it.drain     = 1'b0;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_exec(input opcode_t op, input logic [23:0] operand);
        push_raw_exec({operand, op});
    endtask

    // Apply one transaction to the machine model and form its result
    task automatic execute_step(input logic func, input logic [31:0] word,
                                input logic [15:0] load_addr,
                                input logic [31:0] load_data,
                                output cpu_report_t rep);
        logic [31:0] v;
        logic [31:0] ea;
        opcode_t     op;
        rep = '0;
        v  = {{8{word[31]}}, word[31:8]};
        op = opcode_t'(word[7:0]);
        if (func == FUNC_LOAD) begin
            rep.mem_addr   = load_addr;
            rep.mem_before = cpu_mem[load_addr];
            cpu_mem[load_addr] = load_data;
            rep.mem_after  = load_data;
            rep.mem_write  = 1'b1;
        end else if (!cpu_halt) begin
            cpu_pc    = cpu_pc + 1;
            cpu_count = cpu_count + 1;
            case (op)
                OP_LDC: begin
                    cpu_b = cpu_a;
                    cpu_a = v;
                end
                OP_ADC: cpu_a = cpu_a + v;
                OP_LDL: begin
                    ea = cpu_sp + v;
                    rep.mem_addr   = ea[MEM_ADDR_W-1:0];
                    rep.mem_before = cpu_mem[rep.mem_addr];
                    rep.mem_after  = rep.mem_before;
                    rep.mem_read   = 1'b1;
                    cpu_b = cpu_a;
                    cpu_a = rep.mem_before;
                end
                OP_STL: begin
                    ea = cpu_sp + v;
                    rep.mem_addr   = ea[MEM_ADDR_W-1:0];
                    rep.mem_before = cpu_mem[rep.mem_addr];
                    cpu_mem[rep.mem_addr] = cpu_a;
                    rep.mem_after  = cpu_a;
                    rep.mem_write  = 1'b1;
                    cpu_a = cpu_b;
                end
                OP_LDNL: begin
                    ea = cpu_a + v;
                    rep.mem_addr   = ea[MEM_ADDR_W-1:0];
                    rep.mem_before = cpu_mem[rep.mem_addr];
                    rep.mem_after  = rep.mem_before;
                    rep.mem_read   = 1'b1;
                    cpu_a = rep.mem_before;
                end
                OP_STNL: begin
                    ea = cpu_a + v;
                    rep.mem_addr   = ea[MEM_ADDR_W-1:0];
                    rep.mem_before = cpu_mem[rep.mem_addr];
                    cpu_mem[rep.mem_addr] = cpu_b;
                    rep.mem_after  = cpu_b;
                    rep.mem_write  = 1'b1;
                end
                OP_ADD: cpu_a = cpu_b + cpu_a;
                OP_SUB: cpu_a = cpu_b - cpu_a;
                OP_SHL: cpu_a = (cpu_a >= 32) ? 32'd0 : (cpu_b << cpu_a[4:0]);
                OP_SHR: begin
                    if (cpu_a >= 32)
                        cpu_a = {32{cpu_b[31]}};
                    else
                        cpu_a = $signed(cpu_b) >>> cpu_a[4:0];
                end
                OP_ADJ: cpu_sp = cpu_sp + v;
                OP_A2SP: begin
                    cpu_sp = cpu_a;
                    cpu_a  = cpu_b;
                end
                OP_SP2A: begin
                    cpu_b = cpu_a;
                    cpu_a = cpu_sp;
                end
                OP_CALL: begin
                    cpu_b  = cpu_a;
                    cpu_a  = cpu_pc;
                    cpu_pc = cpu_pc + v;
                end
                OP_RET: begin
                    cpu_pc = cpu_a;
                    cpu_a  = cpu_b;
                end
                OP_BRZ: if (cpu_a == 0) cpu_pc = cpu_pc + v;
                OP_BRLZ: if (cpu_a[31]) cpu_pc = cpu_pc + v;
                OP_BR: cpu_pc = cpu_pc + v;
                OP_HALT: cpu_halt = 1'b1;
                default: ;
            endcase
        end
        rep.next_pc        = cpu_pc;
        rep.reg_a          = cpu_a;
        rep.reg_b          = cpu_b;
        rep.stack_ptr      = cpu_sp;
        rep.halted         = cpu_halt;
        rep.executed_count = cpu_count;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s expected %h actual %h", $time, name, exp, act);
            err_count++;
        end
    endtask

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("two_register_stack_cpu_execute: mismatch");
            $finish;
        end
    end

    // Monitor: check result transactions, then predict from accepted input
    always @(posedge aclk) begin
        cpu_report_t got;
        cpu_report_t exp;
        in_accepted = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got = cpu_report_t'(m_tdata);
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h",
                         $time, m_tdata);
                err_count++;
            end else begin
                exp = expected_reports.pop_front();
                check_field("next_pc", exp.next_pc, got.next_pc);
                check_field("reg_a", exp.reg_a, got.reg_a);
                check_field("reg_b", exp.reg_b, got.reg_b);
                check_field("stack_ptr", exp.stack_ptr, got.stack_ptr);
                check_field("halted", 32'(exp.halted), 32'(got.halted));
                check_field("mem_read", 32'(exp.mem_read), 32'(got.mem_read));
                check_field("mem_write", 32'(exp.mem_write), 32'(got.mem_write));
                check_field("mem_addr", 32'(exp.mem_addr), 32'(got.mem_addr));
                check_field("mem_before", exp.mem_before, got.mem_before);
                check_field("mem_after", exp.mem_after, got.mem_after);
                check_field("executed_count", exp.executed_count,
                            got.executed_count);
            end
        end
        if (in_accepted) begin
            execute_step(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[79:48], exp);
            expected_reports.insert(expected_reports.size(), exp);
            items_accepted++;
        end
    end

    // Driver: hold the current transaction until taken, then idle or advance
    always @(negedge aclk) begin
        cpu_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_accepted) begin
            s_tvalid <= 1'b1;
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap--;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_reports.size() != 0)) begin
            it = pending_items.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= it.func;
            s_tdata  <= {it.load_data, it.load_addr, it.word};
            send_gap = quiet_phase() ? 0 : gap_len();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall m_tready at random
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = quiet_phase() ? 0 : gap_len();
        end
    end

    initial begin
        int unsigned r;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = FUNC_LOAD;
        m_tready       = 1'b0;
        aresetn        = 1'b0;
        err_count      = 0;
        items_accepted = 0;
        cycle_count    = 0;
        in_accepted    = 1'b0;
        send_gap       = 0;
        stall_left     = 0;

        // Machine model after reset
        cpu_a     = RESET_A;
        cpu_b     = RESET_B;
        cpu_sp    = RESET_SP;
        cpu_pc    = '0;
        cpu_halt  = 1'b0;
        cpu_count = '0;
        foreach (cpu_mem[i]) cpu_mem[i] = '0;

        // Directed: field extremes, every opcode but halt, wraps, shifts, branches
        push_load(16'h0000, 32'hFFFF_FFFF);
        push_load(16'hFFFF, 32'h8000_0000);
        push_exec(OP_LDC, 24'h7FFFFF);
        push_exec(OP_LDC, 24'h800000);
        push_exec(OP_ADC, 24'hFFFFFF);
        push_exec(OP_SP2A, 24'h000000);
        push_exec(OP_ADJ, 24'h800000);
        push_exec(OP_LDL, 24'h000000);
        push_exec(OP_STL, 24'hFFFFFF);
        push_exec(OP_LDC, 24'h000000);
        push_exec(OP_LDNL, 24'hFFFFFF);
        push_exec(OP_STNL, 24'h000005);
        push_exec(OP_ADD, 24'h000000);
        push_exec(OP_SUB, 24'h000000);
        push_exec(OP_LDC, 24'hFFFFFB);
        push_exec(OP_LDC, 24'd33);
        push_exec(OP_SHR, 24'h000000);
        push_exec(OP_LDC, 24'd4);
        push_exec(OP_SHL, 24'h000000);
        push_exec(OP_LDC, 24'hFFFFFF);
        push_exec(OP_SHL, 24'h000000);
        push_exec(OP_A2SP, 24'h000000);
        push_exec(OP_CALL, 24'h000010);
        push_exec(OP_RET, 24'h000000);
        push_exec(OP_LDC, 24'h000000);
        push_exec(OP_BRZ, 24'h000007);
        push_exec(OP_LDC, 24'h800000);
        push_exec(OP_BRLZ, 24'hFFFFF0);
        push_exec(OP_BR, 24'hFFFFFD);
        push_raw_exec(32'hFFFF_FF13);
        push_raw_exec(32'h0000_00FF);

        // Random programs without halt, with loads and unknown opcodes mixed in
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                push_load(16'($urandom), $urandom);
            else if (r < 14)
                push_raw_exec({24'($urandom), 8'($urandom_range(19, 255))});
            else if (r < 24)
                push_exec(OP_LDC, 24'($urandom_range(0, 40)));
            else if (r < 30)
                push_exec(OP_LDC, 24'($urandom));
            else
                push_exec(opcode_t'(8'($urandom_range(1, 17))), 24'($urandom));
            if (n % 500 == 499)
                pending_items[pending_items.size()-1].drain = 1'b1;
        end

        // Halt after a full drain, then executes and a load while halted
        push_exec(OP_HALT, 24'($urandom));
        pending_items[pending_items.size()-1].drain = 1'b1;
        push_exec(OP_LDC, 24'h123456);
        push_exec(OP_BR, 24'h000020);
        push_load(16'($urandom), $urandom);
        push_exec(OP_STL, 24'h000000);
        items_total = pending_items.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (items_accepted != items_total || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (err_count == 0)
            $display("two_register_stack_cpu_execute: match");
        else
            $display("two_register_stack_cpu_execute: mismatch");
        $finish;
    end

endmodule
